/* hdl/pp_pkg.sv */
// shared constants and types for the polygon perimeter block
package pp_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int SUM_BITS       = 35;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

endpackage

/* hdl/pp_if.sv */
// vertex and result channel interfaces
interface pp_vertex_if #(
  parameter int COORD_BITS = pp_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         last_vertex;

  modport source (output valid, x_coord, y_coord, last_vertex, input ready);
  modport sink   (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

interface pp_result_if ();
  logic                          valid;
  logic                          ready;
  logic [pp_pkg::SUM_BITS-1:0]   perimeter;
  logic                          saturated;

  modport source (output valid, perimeter, saturated, input ready);
  modport sink   (input valid, perimeter, saturated, output ready);
endinterface

/* hdl/pp_cell.sv */
// one digit step of the fixed-point square root
module pp_cell #(
  parameter int RW   = pp_pkg::COORD_BITS_DEF + pp_pkg::FRAC_BITS_DEF + 1,
  parameter int RADW = 2 * pp_pkg::COORD_BITS_DEF + 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [RADW-1:0] rad_in,
  input  logic [RW-1:0]   root_in,
  input  logic [RW+1:0]   rem_in,
  output logic            out_valid,
  output logic [RADW-1:0] rad_out,
  output logic [RW-1:0]   root_out,
  output logic [RW+1:0]   rem_out
);
  localparam int REMW = RW + 2;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            take;

  always_comb begin
    rem_sh = {rem_in[REMW-3:0], rad_in[RADW-1 -: 2]};
    trial  = {root_in, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_out  <= {rad_in[RADW-3:0], 2'b00};
    root_out <= {root_in[RW-2:0], take};
    rem_out  <= take ? (rem_sh - trial) : rem_sh;
  end

endmodule

/* hdl/pp_root.sv */
// squares, radicand sum and the chain of root cells
module pp_root #(
  parameter int COORD_BITS = pp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [COORD_BITS-1:0]                 adx,
  input  logic [COORD_BITS-1:0]                 ady,
  output logic                                  out_valid,
  output logic [COORD_BITS+FRAC_BITS:0]         out_root
);
  localparam int RW   = COORD_BITS + FRAC_BITS + 1;
  localparam int RADW = 2 * COORD_BITS + 2;
  localparam int SQW  = 2 * COORD_BITS;

  logic            sq_valid;
  logic [SQW-1:0]  sqx;
  logic [SQW-1:0]  sqy;
  logic            rad_valid;
  logic [RADW-1:0] rad;

  logic            c_valid [RW+1];
  logic [RADW-1:0] c_rad   [RW+1];
  logic [RW-1:0]   c_root  [RW+1];
  logic [RW+1:0]   c_rem   [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      rad_valid <= 1'b0;
    end else begin
      sq_valid  <= in_valid;
      rad_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    sqx <= SQW'(adx) * SQW'(adx);
    sqy <= SQW'(ady) * SQW'(ady);
    rad <= RADW'(sqx) + RADW'(sqy);
  end

  assign c_valid[0] = rad_valid;
  assign c_rad[0]   = rad;
  assign c_root[0]  = '0;
  assign c_rem[0]   = '0;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    pp_cell #(
      .RW   (RW),
      .RADW (RADW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .rad_in    (c_rad[i]),
      .root_in   (c_root[i]),
      .rem_in    (c_rem[i]),
      .out_valid (c_valid[i+1]),
      .rad_out   (c_rad[i+1]),
      .root_out  (c_root[i+1]),
      .rem_out   (c_rem[i+1])
    );
  end

  assign out_valid = c_valid[RW];
  assign out_root  = c_root[RW];

endmodule

/* hdl/polygon_perimeter.sv */
// polygon perimeter top level: vertex state, edge issue, sum and result register
// vertex flow: each edge passes the delta registers, the square and radicand registers and the
//   square root chain, one root cell per result bit; a closing vertex also sends the closing
//   edge, and the running sum goes to the result register once the chain has drained; the
//   chain is drained before the next vertex is taken
// reset: clears the vertex state, the running sum and the result valid flag
module polygon_perimeter #(
  parameter int COORD_BITS = pp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pp_pkg::FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  pp_vertex_if.sink   vtx,
  pp_result_if.source res
);
  import pp_pkg::*;

  localparam int RW = COORD_BITS + FRAC_BITS + 1;
  localparam int AW = ((RW > SUM_BITS) ? RW : SUM_BITS) + 1;

  state_t state;
  state_t state_next;

  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic [SUM_BITS-1:0]          length_sum;
  logic                         have_first;
  logic                         cur_last;
  logic                         had_first;
  logic [1:0]                   inflight;

  logic                  d_valid;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;

  logic                  issue;
  logic [COORD_BITS-1:0] ax_mag;
  logic [COORD_BITS-1:0] ay_mag;
  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0] ea_x;
  logic [COORD_BITS-1:0] ea_y;
  logic [COORD_BITS-1:0] eb_x;
  logic [COORD_BITS-1:0] eb_y;

  logic          root_valid;
  logic [RW-1:0] root;
  logic [AW-1:0] acc;

  logic accept;
  logic out_load;

  assign vtx.ready = (state == S_IDLE);
  assign accept    = vtx.valid && vtx.ready;
  assign out_load  = (state == S_OUT) && (!res.valid || res.ready);

  // edge endpoints: previous to new vertex, or closing edge back to the first
  always_comb begin
    if (state == S_IDLE) begin
      ea_x  = prev_x;
      ea_y  = prev_y;
      eb_x  = vtx.x_coord;
      eb_y  = vtx.y_coord;
      issue = accept && have_first;
    end else begin
      ea_x  = prev_x;
      ea_y  = prev_y;
      eb_x  = first_x;
      eb_y  = first_y;
      issue = (state == S_ISSUE) && cur_last && had_first;
    end
    dx     = {ea_x[COORD_BITS-1], ea_x} - {eb_x[COORD_BITS-1], eb_x};
    dy     = {ea_y[COORD_BITS-1], ea_y} - {eb_y[COORD_BITS-1], eb_y};
    ax_mag = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
    ay_mag = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_ISSUE;
      S_ISSUE: state_next = S_DRAIN;
      S_DRAIN: begin
        if (inflight == 2'd0 && !root_valid) begin
          state_next = cur_last ? S_OUT : S_IDLE;
        end
      end
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign acc = AW'(length_sum) + AW'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      length_sum <= '0;
      have_first <= 1'b0;
      cur_last   <= 1'b0;
      had_first  <= 1'b0;
      inflight   <= '0;
      d_valid    <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      state   <= state_next;
      d_valid <= issue;
      inflight <= inflight + 2'(issue) - 2'(root_valid);
      if (accept) begin
        prev_x    <= vtx.x_coord;
        prev_y    <= vtx.y_coord;
        cur_last  <= vtx.last_vertex;
        had_first <= have_first;
        if (!have_first) begin
          first_x    <= vtx.x_coord;
          first_y    <= vtx.y_coord;
          have_first <= 1'b1;
        end
      end
      if (root_valid) begin
        length_sum <= (acc > AW'(SUM_MAX)) ? SUM_MAX : acc[SUM_BITS-1:0];
      end
      if (out_load) begin
        length_sum <= '0;
        have_first <= 1'b0;
        res.valid  <= 1'b1;
      end else if (res.ready) begin
        res.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    adx <= ax_mag;
    ady <= ay_mag;
    if (out_load) begin
      res.perimeter <= length_sum;
      res.saturated <= (length_sum == SUM_MAX);
    end
  end

  pp_root #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .adx       (adx),
    .ady       (ady),
    .out_valid (root_valid),
    .out_root  (root)
  );

  a_inflight_max: assert property (@(posedge clk) disable iff (rst)
    inflight != 2'd3)
    else $error("more than two edges in flight");

  a_root_in_drain: assert property (@(posedge clk) disable iff (rst)
    root_valid |-> (state == S_DRAIN))
    else $error("edge length arrived outside drain");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.saturated == (res.perimeter == SUM_MAX)))
    else $error("saturated flag disagrees with perimeter");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (!have_first && length_sum == '0))
    else $error("polygon state not cleared after result");

endmodule

/* tb/tb_polygon_perimeter.sv */
// testbench for polygon_perimeter: streams polygon vertices, predicts each perimeter word, checks it
`timescale 1ns / 1ps

module tb_polygon_perimeter;
  import pp_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int FRAC_W = FRAC_BITS_DEF;
  localparam int ROOT_W = COORD_W + FRAC_W + 2;
  localparam int SQ_W = 2 * COORD_W + 2;
  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SAT_VERTICES = 1460;
  localparam int ITEMS_PER_PHASE = 200;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum int {
    SPREAD_FULL,
    SPREAD_LOCAL,
    SPREAD_CORNERS
  } coord_spread_t;

  typedef struct {
    logic [SUM_BITS-1:0] perimeter;
    logic                saturated;
  } perim_word_t;

  logic clk;
  logic rst;

  pp_vertex_if #(.COORD_BITS(COORD_W)) vtx_if ();
  pp_result_if res_if ();

  polygon_perimeter #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .vtx(vtx_if),
    .res(res_if)
  );

  perim_word_t expected_perims[$];

  logic signed [COORD_W-1:0] poly_first_x;
  logic signed [COORD_W-1:0] poly_first_y;
  logic signed [COORD_W-1:0] poly_prev_x;
  logic signed [COORD_W-1:0] poly_prev_y;
  logic [SUM_BITS-1:0]       poly_length_sum;
  logic                      poly_open;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  int mismatches;
  int vertices_sent;
  int polygons_closed;
  int perims_checked;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [ROOT_W-1:0] fixed_sqrt(input logic [SQ_W-1:0] sq);
    logic [63:0]       radicand;
    logic [63:0]       trial_sq;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    radicand = {{(64-SQ_W){1'b0}}, sq} << (2 * FRAC_W);
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ROOT_W'(1) << b);
      trial_sq = 64'(trial) * 64'(trial);
      if (trial_sq <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic logic [ROOT_W-1:0] edge_length(
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx,
    input logic signed [COORD_W-1:0] by
  );
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        ux;
    logic [COORD_W:0]        uy;
    logic [SQ_W-1:0]         sq;
    dx = ax - bx;
    dy = ay - by;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    sq = SQ_W'(ux) * SQ_W'(ux) + SQ_W'(uy) * SQ_W'(uy);
    return fixed_sqrt(sq);
  endfunction

  function automatic logic [SUM_BITS-1:0] clamp_add(
    input logic [SUM_BITS-1:0] sum,
    input logic [ROOT_W-1:0]   len
  );
    logic [SUM_BITS:0] s;
    s = (SUM_BITS+1)'(sum) + (SUM_BITS+1)'(len);
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_BITS-1:0];
  endfunction

  task automatic track_vertex(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic                      last
  );
    perim_word_t word;
    if (!poly_open) begin
      poly_first_x = x;
      poly_first_y = y;
      poly_length_sum = '0;
      poly_open = 1'b1;
    end else begin
      poly_length_sum = clamp_add(poly_length_sum, edge_length(poly_prev_x, poly_prev_y, x, y));
    end
    poly_prev_x = x;
    poly_prev_y = y;
    if (last) begin
      poly_length_sum = clamp_add(poly_length_sum, edge_length(x, y, poly_first_x, poly_first_y));
      word.perimeter = poly_length_sum;
      word.saturated = (poly_length_sum == SUM_MAX);
      expected_perims.push_back(word);
      poly_length_sum = '0;
      poly_open = 1'b0;
      polygons_closed++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_vertex(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic                      last
  );
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      vtx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_if.valid <= 1'b1;
    vtx_if.x_coord <= x;
    vtx_if.y_coord <= y;
    vtx_if.last_vertex <= last;
    @(posedge clk);
    while (!vtx_if.ready) @(posedge clk);
    vertices_sent++;
    track_vertex(x, y, last);
  endtask

  task automatic wait_results_drained();
    vtx_if.valid <= 1'b0;
    while (expected_perims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] random_coord(
    input coord_spread_t             spread,
    input logic signed [COORD_W-1:0] anchor
  );
    logic signed [COORD_W-1:0] c;
    case (spread)
      SPREAD_FULL: begin
        c = COORD_W'($urandom);
      end
      SPREAD_LOCAL: begin
        c = anchor + COORD_W'($urandom_range(64)) - COORD_W'(32);
      end
      default: begin
        case ($urandom_range(3))
          0: c = COORD_MIN;
          1: c = COORD_MAX;
          2: c = '0;
          default: c = '1;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic test_directed_shapes();
    // lone vertices
    send_vertex('0, '0, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    // two vertices, full diagonal out and back
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    // 3-4-5 triangle
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd3, 16'sd0, 1'b0);
    send_vertex(16'sd3, 16'sd4, 1'b1);
    // full range square
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    // repeated point, zero length edges
    send_vertex('1, '1, 1'b0);
    send_vertex('1, '1, 1'b0);
    send_vertex('1, '1, 1'b1);
    // axis edge out and back, then a four vertex polygon with oblique edges
    send_vertex(COORD_MAX, '0, 1'b0);
    send_vertex(COORD_MIN, '0, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, '0, 1'b0);
    send_vertex('0, COORD_MIN, 1'b0);
    send_vertex(16'sd12345, -16'sd12345, 1'b1);
  endtask

  task automatic test_random_polygons(input int n_items);
    int                        sent;
    int                        n_verts;
    int                        r;
    coord_spread_t             spread;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    sent = 0;
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 50) n_verts = $urandom_range(1, 4);
      else if (r < 85) n_verts = $urandom_range(5, 12);
      else n_verts = $urandom_range(13, 40);
      r = $urandom_range(99);
      spread = (r < 45) ? SPREAD_FULL : (r < 80) ? SPREAD_LOCAL : SPREAD_CORNERS;
      for (int v = 0; v < n_verts; v++) begin
        if (v == 0 || $urandom_range(99) >= 15) begin
          x = random_coord(spread, x);
          y = random_coord(spread, y);
        end
        send_vertex(x, y, v == n_verts - 1);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    wait_results_drained();
    rx_hold_left = RX_HOLD_CYCLES;
    for (int p = 0; p < 8; p++) begin
      send_vertex(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
      send_vertex(COORD_W'($urandom), COORD_W'($urandom), 1'b1);
    end
    wait_results_drained();
  endtask

  task automatic test_saturation();
    // diagonal zigzag long enough to clamp the sum and keep it there
    for (int v = 0; v < SAT_VERTICES; v++) begin
      if (v % 2 == 0) send_vertex(COORD_MIN, COORD_MIN, v == SAT_VERTICES - 1);
      else send_vertex(COORD_MAX, COORD_MAX, v == SAT_VERTICES - 1);
    end
    send_vertex(16'sd7, -16'sd9, 1'b1);
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_perims
    perim_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_perims.size() == 0) begin
        report_mismatch($sformatf("perimeter word %0d with nothing expected", res_if.perimeter));
      end else begin
        want = expected_perims.pop_front();
        perims_checked++;
        if (res_if.perimeter !== want.perimeter)
          report_mismatch($sformatf("perimeter %0d, expected %0d", res_if.perimeter,
                                    want.perimeter));
        if (res_if.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b", res_if.saturated,
                                    want.saturated));
      end
    end
  end

  initial begin
    mismatches = 0;
    vertices_sent = 0;
    polygons_closed = 0;
    perims_checked = 0;
    rx_hold_left = 0;
    poly_open = 1'b0;
    poly_length_sum = '0;
    poly_first_x = '0;
    poly_first_y = '0;
    poly_prev_x = '0;
    poly_prev_y = '0;
    tx_idle_pct = 13;
    rx_idle_pct = 73;
    rst <= 1'b1;
    vtx_if.valid <= 1'b0;
    vtx_if.x_coord <= '0;
    vtx_if.y_coord <= '0;
    vtx_if.last_vertex <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_shapes();
    test_random_polygons(ITEMS_PER_PHASE);
    wait_results_drained();

    tx_idle_pct = 73;
    rx_idle_pct = 13;
    test_backpressure();
    test_random_polygons(ITEMS_PER_PHASE);
    wait_results_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_saturation();
    test_random_polygons(ITEMS_PER_PHASE);
    wait_results_drained();

    $display("covered %0d vertices in %0d polygons, %0d perimeter words checked",
             vertices_sent, polygons_closed, perims_checked);
    $display("incl. lone vertices, full range edges, a clamped sum and a long output stall");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/pp_pkg.sv
hdl/pp_if.sv
hdl/pp_cell.sv
hdl/pp_root.sv
hdl/polygon_perimeter.sv
tb/tb_polygon_perimeter.sv
